// ----- src/odgc_pkg.sv -----
// ----------------------------------------------------------------------------
// odgc_pkg
// Shared types and constants for the octahedral direction to grid cell block.
// ----------------------------------------------------------------------------
package odgc_pkg;

  localparam int unsigned CHUNK_W     = 11;
  localparam int unsigned CELL_W      = 10;
  localparam int unsigned QUOT_W      = 11;
  localparam logic [CHUNK_W-1:0] CHUNK_RESET = 11'd16;
  localparam logic [CHUNK_W-1:0] CELL_MAX    = 11'd1023;

  typedef struct packed {
    logic valid;
    logic zero;
  } odgc_ctl_t;

endpackage

// ----- src/octahedral_direction_to_grid_cell.sv -----
// ----------------------------------------------------------------------------
// octahedral_direction_to_grid_cell
// Maps a signed direction vector to a cell of an N by N octahedral grid.
// ----------------------------------------------------------------------------
// Usage:
//   Input transaction: in_dir_x/y/z taken at a rising edge with start high and
//   busy low. busy stays low: one transaction may enter every cycle.
//   Result: out_cell_x, out_cell_y and out_zero_vector are shown for one
//   cycle with out_valid high, once the transaction has passed the front
//   stages, the division cells and the output register. There is
//   no back-pressure; results must be taken as they come.
//   Throughput is one transaction per cycle. The pipeline is a row of 11
//   division cells, one quotient bit each, behind an input stage (fold and
//   sum) and a scaling multiplier stage, plus the clamping output register.
//   Configuration: cfg_chunk_count is written when cfg_valid is high
//   (cfg_ready is always high); write only while no transaction is in
//   flight. Reset sets the grid size to 16 and empties the pipeline.
// ----------------------------------------------------------------------------
module octahedral_direction_to_grid_cell #(
  parameter int unsigned COMPONENT_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [COMPONENT_WIDTH-1:0]    in_dir_x,
  input  logic [COMPONENT_WIDTH-1:0]    in_dir_y,
  input  logic [COMPONENT_WIDTH-1:0]    in_dir_z,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [odgc_pkg::CHUNK_W-1:0]  cfg_chunk_count,
  output logic                          out_valid,
  output logic [odgc_pkg::CELL_W-1:0]   out_cell_x,
  output logic [odgc_pkg::CELL_W-1:0]   out_cell_y,
  output logic                          out_zero_vector
);
  import odgc_pkg::*;

  localparam int unsigned NUM_W = COMPONENT_WIDTH + 3;
  localparam int unsigned REM_W = NUM_W + QUOT_W;
  localparam int unsigned LAT   = QUOT_W + 3;

  logic [CHUNK_W-1:0] chunk_r, chunk_nxt;
  logic               accept;

  odgc_ctl_t          ctl   [QUOT_W+1];
  logic [NUM_W-1:0]   div   [QUOT_W+1];
  logic [REM_W-1:0]   rem_x [QUOT_W+1];
  logic [REM_W-1:0]   rem_y [QUOT_W+1];
  logic [QUOT_W-1:0]  quo_x [QUOT_W+1];
  logic [QUOT_W-1:0]  quo_y [QUOT_W+1];

  logic [CHUNK_W-1:0] limit;
  logic               out_valid_r;
  logic               zero_r, zero_nxt;
  logic [CELL_W-1:0]  cell_x_r, cell_x_nxt, cell_y_r, cell_y_nxt;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_comb begin
    chunk_nxt = (cfg_valid && cfg_ready) ? cfg_chunk_count : chunk_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_r <= CHUNK_RESET;
    end else begin
      chunk_r <= chunk_nxt;
    end
  end

  odgc_front #(
    .COMP_W (COMPONENT_WIDTH),
    .NUM_W  (NUM_W),
    .REM_W  (REM_W)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept_i (accept),
    .dir_x_i  (in_dir_x),
    .dir_y_i  (in_dir_y),
    .dir_z_i  (in_dir_z),
    .chunk_i  (chunk_r),
    .ctl_o    (ctl[0]),
    .div_o    (div[0]),
    .prod_x_o (rem_x[0]),
    .prod_y_o (rem_y[0])
  );

  assign quo_x[0] = '0;
  assign quo_y[0] = '0;

  for (genvar i = 0; i < QUOT_W; i++) begin : g_cell
    odgc_div_cell #(
      .NUM_W (NUM_W),
      .REM_W (REM_W),
      .SHIFT (QUOT_W - 1 - i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl_i   (ctl[i]),
      .div_i   (div[i]),
      .rem_x_i (rem_x[i]),
      .rem_y_i (rem_y[i]),
      .quo_x_i (quo_x[i]),
      .quo_y_i (quo_y[i]),
      .ctl_o   (ctl[i+1]),
      .div_o   (div[i+1]),
      .rem_x_o (rem_x[i+1]),
      .rem_y_o (rem_y[i+1]),
      .quo_x_o (quo_x[i+1]),
      .quo_y_o (quo_y[i+1])
    );
  end

  // clamp to the last cell; an all-zero vector lands on cell 0,0
  always_comb begin
    limit = (chunk_r == '0) ? '0 : chunk_r - CHUNK_W'(1);
    if (limit > CELL_MAX) begin
      limit = CELL_MAX;
    end
    zero_nxt   = ctl[QUOT_W].zero;
    cell_x_nxt = CELL_W'((quo_x[QUOT_W] > limit) ? limit : quo_x[QUOT_W]);
    cell_y_nxt = CELL_W'((quo_y[QUOT_W] > limit) ? limit : quo_y[QUOT_W]);
    if (ctl[QUOT_W].zero) begin
      cell_x_nxt = '0;
      cell_y_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl[QUOT_W].valid;
    end
  end

  always_ff @(posedge clk) begin
    zero_r   <= zero_nxt;
    cell_x_r <= cell_x_nxt;
    cell_y_r <= cell_y_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_cell_x      = cell_x_r;
  assign out_cell_y      = cell_y_r;
  assign out_zero_vector = zero_r;

`ifndef SYNTHESIS
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LAT out_valid)
    else $error("transaction did not emerge after the pipeline latency");

  a_no_spurious : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LAT))
    else $error("result strobe without a matching transaction");

  a_zero_cells : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_vector) |-> (out_cell_x == '0 && out_cell_y == '0))
    else $error("zero vector with non-zero cell");

  a_clamp : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (CHUNK_W'(out_cell_x) <= limit && CHUNK_W'(out_cell_y) <= limit))
    else $error("cell index beyond the grid");

  a_reset_idle : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe straight after reset");
`endif

endmodule

// ----- src/odgc_front.sv -----
// ----------------------------------------------------------------------------
// odgc_front
// Magnitudes, sum, hemisphere fold and scaling by the grid size, two stages.
// ----------------------------------------------------------------------------
module odgc_front #(
  parameter int unsigned COMP_W = 16,
  parameter int unsigned NUM_W  = COMP_W + 3,
  parameter int unsigned REM_W  = NUM_W + 11
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      accept_i,
  input  logic [COMP_W-1:0]         dir_x_i,
  input  logic [COMP_W-1:0]         dir_y_i,
  input  logic [COMP_W-1:0]         dir_z_i,
  input  logic [odgc_pkg::CHUNK_W-1:0] chunk_i,
  output odgc_pkg::odgc_ctl_t       ctl_o,
  output logic [NUM_W-1:0]          div_o,
  output logic [REM_W-1:0]          prod_x_o,
  output logic [REM_W-1:0]          prod_y_o
);
  import odgc_pkg::*;

  logic [COMP_W-1:0] ax, ay, az;
  logic [NUM_W-1:0]  sum, sx_ext, sy_ext;
  logic              lower;

  odgc_ctl_t         ctl1_r, ctl1_nxt, ctl2_r;
  logic [NUM_W-1:0]  numx_r, numx_nxt, numy_r, numy_nxt, div1_r, div1_nxt, div2_r;
  logic [REM_W-1:0]  px_r, px_nxt, py_r, py_nxt;

  always_comb begin
    ax     = dir_x_i[COMP_W-1] ? COMP_W'(-dir_x_i) : dir_x_i;
    ay     = dir_y_i[COMP_W-1] ? COMP_W'(-dir_y_i) : dir_y_i;
    az     = dir_z_i[COMP_W-1] ? COMP_W'(-dir_z_i) : dir_z_i;
    sum    = NUM_W'(ax) + NUM_W'(ay) + NUM_W'(az);
    lower  = dir_z_i[COMP_W-1];
    sx_ext = {{(NUM_W-COMP_W){dir_x_i[COMP_W-1]}}, dir_x_i};
    sy_ext = {{(NUM_W-COMP_W){dir_y_i[COMP_W-1]}}, dir_y_i};

    if (!lower) begin
      numx_nxt = sx_ext + sum;
      numy_nxt = sy_ext + sum;
    end else begin
      numx_nxt = dir_x_i[COMP_W-1] ? NUM_W'(ay) : (sum << 1) - NUM_W'(ay);
      numy_nxt = dir_y_i[COMP_W-1] ? NUM_W'(ax) : (sum << 1) - NUM_W'(ax);
    end
    div1_nxt       = sum << 1;
    ctl1_nxt.valid = accept_i;
    ctl1_nxt.zero  = (sum == '0);

    px_nxt = {{(REM_W-CHUNK_W){1'b0}}, chunk_i} * {{(REM_W-NUM_W){1'b0}}, numx_r};
    py_nxt = {{(REM_W-CHUNK_W){1'b0}}, chunk_i} * {{(REM_W-NUM_W){1'b0}}, numy_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
    end else begin
      ctl1_r <= ctl1_nxt;
      ctl2_r <= ctl1_r;
    end
  end

  always_ff @(posedge clk) begin
    numx_r <= numx_nxt;
    numy_r <= numy_nxt;
    div1_r <= div1_nxt;
    px_r   <= px_nxt;
    py_r   <= py_nxt;
    div2_r <= div1_r;
  end

  assign ctl_o    = ctl2_r;
  assign div_o    = div2_r;
  assign prod_x_o = px_r;
  assign prod_y_o = py_r;

endmodule

// ----- src/odgc_div_cell.sv -----
// ----------------------------------------------------------------------------
// odgc_div_cell
// One quotient bit of the restoring division, both axes, registered.
// ----------------------------------------------------------------------------
module odgc_div_cell #(
  parameter int unsigned NUM_W = 19,
  parameter int unsigned REM_W = 30,
  parameter int unsigned SHIFT = 10
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  odgc_pkg::odgc_ctl_t         ctl_i,
  input  logic [NUM_W-1:0]            div_i,
  input  logic [REM_W-1:0]            rem_x_i,
  input  logic [REM_W-1:0]            rem_y_i,
  input  logic [odgc_pkg::QUOT_W-1:0] quo_x_i,
  input  logic [odgc_pkg::QUOT_W-1:0] quo_y_i,
  output odgc_pkg::odgc_ctl_t         ctl_o,
  output logic [NUM_W-1:0]            div_o,
  output logic [REM_W-1:0]            rem_x_o,
  output logic [REM_W-1:0]            rem_y_o,
  output logic [odgc_pkg::QUOT_W-1:0] quo_x_o,
  output logic [odgc_pkg::QUOT_W-1:0] quo_y_o
);
  import odgc_pkg::*;

  logic [REM_W-1:0]  shifted;
  logic              ge_x, ge_y;
  odgc_ctl_t         ctl_r;
  logic [NUM_W-1:0]  div_r;
  logic [REM_W-1:0]  rem_x_r, rem_x_nxt, rem_y_r, rem_y_nxt;
  logic [QUOT_W-1:0] quo_x_r, quo_x_nxt, quo_y_r, quo_y_nxt;

  always_comb begin
    shifted   = REM_W'(div_i) << SHIFT;
    ge_x      = (rem_x_i >= shifted);
    ge_y      = (rem_y_i >= shifted);
    rem_x_nxt = ge_x ? rem_x_i - shifted : rem_x_i;
    rem_y_nxt = ge_y ? rem_y_i - shifted : rem_y_i;
    quo_x_nxt = quo_x_i;
    quo_y_nxt = quo_y_i;
    quo_x_nxt[SHIFT] = ge_x;
    quo_y_nxt[SHIFT] = ge_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    div_r   <= div_i;
    rem_x_r <= rem_x_nxt;
    rem_y_r <= rem_y_nxt;
    quo_x_r <= quo_x_nxt;
    quo_y_r <= quo_y_nxt;
  end

  assign ctl_o   = ctl_r;
  assign div_o   = div_r;
  assign rem_x_o = rem_x_r;
  assign rem_y_o = rem_y_r;
  assign quo_x_o = quo_x_r;
  assign quo_y_o = quo_y_r;

endmodule

// ----- verif/odgc_cell_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odgc_cell_checker
// Watches the direction, grid size and cell channels of the octahedral
// direction to grid cell block. Keeps its own grid size, works out the cell
// for every accepted direction in exact integer arithmetic, and compares each
// cell transaction with the oldest one still due.
// ----------------------------------------------------------------------------
module odgc_cell_checker #(
  parameter int unsigned CW = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic [CW-1:0]                 in_dir_x,
  input  logic [CW-1:0]                 in_dir_y,
  input  logic [CW-1:0]                 in_dir_z,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [odgc_pkg::CHUNK_W-1:0]  cfg_chunk_count,
  input  logic                          out_valid,
  input  logic [odgc_pkg::CELL_W-1:0]   out_cell_x,
  input  logic [odgc_pkg::CELL_W-1:0]   out_cell_y,
  input  logic                          out_zero_vector,
  output int unsigned                   mismatches,
  output int unsigned                   pending_cells,
  output int unsigned                   cells_checked
);

  import odgc_pkg::*;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_x;
    logic [CELL_W-1:0] cell_y;
    logic              zero_vector;
  } grid_cell_t;

  grid_cell_t        cells_due[$];
  logic [CHUNK_W-1:0] grid_size;

  function automatic u64_t axis_span(longint c, u64_t other, bit lower, u64_t sum);
    if (!lower) begin
      return u64_t'(c) + sum;
    end
    if (c >= 0) begin
      return 2 * sum - other;
    end
    return other;
  endfunction

  function automatic logic [CELL_W-1:0] scaled_index(logic [CHUNK_W-1:0] n, u64_t span,
                                                     u64_t sum);
    u64_t q;
    u64_t lim;
    q   = (u64_t'(n) * span) / (2 * sum);
    lim = (n == 0) ? 0 : u64_t'(n) - 1;
    if (lim > u64_t'(CELL_MAX)) begin
      lim = u64_t'(CELL_MAX);
    end
    if (q > lim) begin
      q = lim;
    end
    return q[CELL_W-1:0];
  endfunction

  function automatic grid_cell_t predict_cell(logic [CW-1:0] rx, logic [CW-1:0] ry,
                                              logic [CW-1:0] rz, logic [CHUNK_W-1:0] n);
    longint     sx;
    longint     sy;
    longint     sz;
    u64_t       ax;
    u64_t       ay;
    u64_t       sum;
    bit         lower;
    grid_cell_t r;
    sx    = longint'($signed(rx));
    sy    = longint'($signed(ry));
    sz    = longint'($signed(rz));
    ax    = (sx < 0) ? u64_t'(-sx) : u64_t'(sx);
    ay    = (sy < 0) ? u64_t'(-sy) : u64_t'(sy);
    sum   = ax + ay + ((sz < 0) ? u64_t'(-sz) : u64_t'(sz));
    lower = (sz < 0);
    r     = '0;
    if (sum == 0) begin
      r.zero_vector = 1'b1;
      return r;
    end
    r.cell_x = scaled_index(n, axis_span(sx, ay, lower, sum), sum);
    r.cell_y = scaled_index(n, axis_span(sy, ax, lower, sum), sum);
    return r;
  endfunction

  initial begin
    mismatches    = 0;
    pending_cells = 0;
    cells_checked = 0;
    grid_size     = CHUNK_RESET;
  end

  always @(posedge clk) begin
    grid_cell_t due;
    if (!rst_n) begin
      grid_size = CHUNK_RESET;
      cells_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        grid_size = cfg_chunk_count;
      end
      if (out_valid) begin
        if (cells_due.size() == 0) begin
          $error("cell transaction with nothing due: x=%0d y=%0d zero=%0b",
                 out_cell_x, out_cell_y, out_zero_vector);
          mismatches++;
        end else begin
          due = cells_due.pop_front();
          cells_checked++;
          if (out_cell_x !== due.cell_x) begin
            $error("cell_x: expected %0d, actual %0d", due.cell_x, out_cell_x);
            mismatches++;
          end
          if (out_cell_y !== due.cell_y) begin
            $error("cell_y: expected %0d, actual %0d", due.cell_y, out_cell_y);
            mismatches++;
          end
          if (out_zero_vector !== due.zero_vector) begin
            $error("zero_vector: expected %0b, actual %0b", due.zero_vector,
                   out_zero_vector);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        cells_due.push_back(predict_cell(in_dir_x, in_dir_y, in_dir_z, grid_size));
      end
    end
    pending_cells = cells_due.size();
  end

endmodule

// ----- verif/octahedral_direction_to_grid_cell_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// octahedral_direction_to_grid_cell_tb
// Drives directions into the octahedral grid cell block under a range of grid
// sizes, from zero and one up to the full register range, with random bursts
// of idle cycles. A separate checker predicts and compares every cell.
// ----------------------------------------------------------------------------
module octahedral_direction_to_grid_cell_tb;

  import odgc_pkg::*;

  localparam int unsigned COMP_W      = 16;
  localparam int unsigned N_DIRECTED  = 23;
  localparam int unsigned N_PHASES    = 8;
  localparam int unsigned RAND_ITEMS  = 50;
  localparam int unsigned CALM_TAIL   = 40;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_WAIT  = 20;

  typedef logic [COMP_W-1:0] comp_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  comp_t              in_dir_x;
  comp_t              in_dir_y;
  comp_t              in_dir_z;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CHUNK_W-1:0] cfg_chunk_count;
  logic               out_valid;
  logic [CELL_W-1:0]  out_cell_x;
  logic [CELL_W-1:0]  out_cell_y;
  logic               out_zero_vector;

  int unsigned mismatches;
  int unsigned pending_cells;
  int unsigned cells_checked;
  int unsigned idle_cycles;
  int unsigned dirs_sent;
  int unsigned zero_dirs;
  int unsigned folded_dirs;
  int unsigned sizes_run;

  comp_t directed_dirs [N_DIRECTED][3] = '{
    '{16'sd0,      16'sd0,      16'sd0},
    '{16'sd32767,  16'sd0,      16'sd0},
    '{-16'sd32767, 16'sd0,      16'sd0},
    '{16'sd0,      16'sd32767,  16'sd0},
    '{16'sd0,      -16'sd32767, 16'sd0},
    '{16'sd0,      16'sd0,      16'sd32767},
    '{16'sd0,      16'sd0,      -16'sd32767},
    '{16'h8000,    16'h8000,    16'h8000},
    '{16'sd32767,  16'sd32767,  16'sd32767},
    '{-16'sd32767, -16'sd32767, -16'sd32767},
    '{16'sd32767,  -16'sd32767, -16'sd1},
    '{-16'sd1,     16'sd1,      -16'sd1},
    '{16'sd0,      -16'sd5,     -16'sd3},
    '{16'sd7,      16'sd0,      -16'sd9},
    '{16'sd1,      16'sd1,      16'sd0},
    '{-16'sd1,     16'sd1,      16'sd0},
    '{16'sd1,      16'sd0,      16'sd0},
    '{16'sd3,      -16'sd5,     16'sd7},
    '{-16'sd12345, 16'sd23456,  -16'sd7},
    '{16'h8000,    16'sd0,      16'sd0},
    '{16'sd0,      16'sd0,      16'h8000},
    '{16'sd0,      16'sd0,      16'sd0},
    '{-16'sd1,     -16'sd1,     -16'sd1}
  };

  octahedral_direction_to_grid_cell #(
    .COMPONENT_WIDTH (COMP_W)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_dir_x        (in_dir_x),
    .in_dir_y        (in_dir_y),
    .in_dir_z        (in_dir_z),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_chunk_count (cfg_chunk_count),
    .out_valid       (out_valid),
    .out_cell_x      (out_cell_x),
    .out_cell_y      (out_cell_y),
    .out_zero_vector (out_zero_vector)
  );

  odgc_cell_checker #(
    .CW (COMP_W)
  ) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_dir_x        (in_dir_x),
    .in_dir_y        (in_dir_y),
    .in_dir_z        (in_dir_z),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_chunk_count (cfg_chunk_count),
    .out_valid       (out_valid),
    .out_cell_x      (out_cell_x),
    .out_cell_y      (out_cell_y),
    .out_zero_vector (out_zero_vector),
    .mismatches      (mismatches),
    .pending_cells   (pending_cells),
    .cells_checked   (cells_checked)
  );

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("** octahedral_direction_to_grid_cell: FAILED **");
        $finish;
      end
    end
  end

  task automatic send_direction(comp_t x, comp_t y, comp_t z, bit may_idle);
    if (may_idle && $urandom_range(0, 4) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    start    <= 1'b1;
    in_dir_x <= x;
    in_dir_y <= y;
    in_dir_z <= z;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    dirs_sent++;
    if (x == 0 && y == 0 && z == 0) begin
      zero_dirs++;
    end
    if (z[COMP_W-1]) begin
      folded_dirs++;
    end
  endtask

  task automatic write_grid_size(logic [CHUNK_W-1:0] n);
    start <= 1'b0;
    @(negedge clk);
    while (pending_cells != 0) @(negedge clk);
    @(posedge clk);
    cfg_valid       <= 1'b1;
    cfg_chunk_count <= n;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
    sizes_run++;
  endtask

  function automatic comp_t pick_component(int unsigned mode);
    comp_t edges [6] = '{16'h8000, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32767};
    case (mode)
      0:       return comp_t'($urandom);
      1:       return comp_t'(int'($urandom_range(0, 8)) - 4);
      2:       return comp_t'(int'($urandom_range(0, 64)) - 32);
      default: return edges[$urandom_range(0, 5)];
    endcase
  endfunction

  task automatic send_random_direction(bit may_idle);
    comp_t x;
    comp_t y;
    comp_t z;
    int unsigned mode;
    mode = $urandom_range(0, 5);
    x = pick_component(mode == 4 ? 3 : (mode == 5 ? 0 : mode));
    y = pick_component(mode == 4 ? 3 : (mode == 5 ? 1 : mode));
    z = pick_component(mode == 4 ? 3 : (mode == 5 ? 2 : mode));
    if ($urandom_range(0, 3) == 0) begin
      z[COMP_W-1] = 1'b1;
    end
    if ($urandom_range(0, 39) == 0) begin
      x = '0;
      y = '0;
      z = '0;
    end
    send_direction(x, y, z, may_idle);
  endtask

  initial begin
    logic [CHUNK_W-1:0] sizes [N_PHASES];
    bit                 calm;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_dir_x        = '0;
    in_dir_y        = '0;
    in_dir_z        = '0;
    cfg_valid       = 1'b0;
    cfg_chunk_count = CHUNK_RESET;
    idle_cycles     = 0;
    dirs_sent       = 0;
    zero_dirs       = 0;
    folded_dirs     = 0;
    sizes_run       = 1;
    sizes = '{CHUNK_RESET, 11'd1, 11'd1024, 11'd0, 11'd2047, 11'd17,
              CHUNK_W'($urandom_range(2, 1023)), 11'd16};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) begin
      send_direction(directed_dirs[i][0], directed_dirs[i][1], directed_dirs[i][2],
                     (i % 4) == 1);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      if (p != 0) begin
        write_grid_size(sizes[p]);
      end
      for (int i = 0; i < RAND_ITEMS; i++) begin
        calm = ((i / 12) % 3 == 2) ||
               (p == N_PHASES - 1 && i >= RAND_ITEMS - CALM_TAIL);
        send_random_direction(!calm);
      end
    end

    start <= 1'b0;
    @(negedge clk);
    while (pending_cells != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    @(negedge clk);

    $display("Sent %0d directions over %0d grid sizes (0, 1, 16, 17, 1024, 2047, random)",
             dirs_sent, sizes_run);
    $display("Checked %0d cells; %0d all-zero and %0d folded-hemisphere directions",
             cells_checked, zero_dirs, folded_dirs);
    if (mismatches == 0) begin
      $display("** octahedral_direction_to_grid_cell: PASSED **");
    end else begin
      $display("** octahedral_direction_to_grid_cell: FAILED **");
    end
    $finish;
  end

endmodule
